FILE: rtl/pqsr_pkg.sv
// shared types and codes for the priority queue with select-remove
// no dependencies
package pqsr_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_EXACT  = 2'd1;
  localparam logic [1:0] REQ_ATLEAST = 2'd2;
  localparam logic [1:0] REQ_MIN    = 2'd3;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_REMOVED   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] item_tag;
    logic [7:0] item_priority;
  } pqsr_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_tag;
    logic [7:0] out_priority;
    logic [4:0] occupancy;
  } pqsr_out_t;

  typedef struct packed {
    logic [7:0] tag;
    logic [7:0] prio;
  } pqsr_entry_t;

  typedef struct packed {
    logic ld_req;
    logic ins;
    logic scan_en;
    logic shift_init;
    logic shift_en;
    logic rem_commit;
    logic out_ld;
  } pqsr_cmd_t;

  typedef struct packed {
    logic is_ins;
    logic scan_done;
    logic found;
    logic shift_done;
    logic out_free;
  } pqsr_stat_t;

endpackage

FILE: rtl/pqsr_ctrl.sv
// controller state machine for the priority queue
// depends on pqsr_pkg
module pqsr_ctrl
  import pqsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  pqsr_stat_t stat,
  output pqsr_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_req = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_ins) begin
          cmd.ins = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_done) begin
          if (stat.found) begin
            cmd.shift_init = 1'b1;
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift_en = 1'b1;
        if (stat.shift_done) begin
          cmd.rem_commit = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/pqsr_dp.sv
// datapath: entry memory, scan and gap-closing pointers, result register
// depends on pqsr_pkg
module pqsr_dp
  import pqsr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pqsr_in_t   in_data,
  input  pqsr_cmd_t  cmd,
  output pqsr_stat_t stat,
  output logic       out_valid,
  input  logic       out_stall,
  output pqsr_out_t  out_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  pqsr_entry_t mem [QUEUE_DEPTH];

  logic [1:0]    req_r;
  logic [7:0]    tag_r;
  logic [7:0]    bound_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  pqsr_entry_t   rd_data_r;
  logic          found_r, found_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  pqsr_entry_t   best_e_r, best_e_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  pqsr_entry_t   res_e_r, res_e_nxt;
  logic          out_valid_r;
  pqsr_out_t     out_data_r;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] waddr;
  pqsr_entry_t   wdata;
  logic          hit;
  logic          full;
  logic [31:0]   occ_ext;

  assign full    = (count_r >= CW'(QUEUE_DEPTH));
  assign occ_ext = 32'(count_r);

  always_comb begin
    if (req_r == REQ_EXACT) begin
      hit = (rd_data_r.prio == bound_r) && !found_r;
    end else begin
      hit = (rd_data_r.prio >= bound_r) && (!found_r || (rd_data_r.prio < best_e_r.prio));
    end
  end

  always_comb begin
    rd_en          = 1'b0;
    rd_addr        = ptr_r[AW-1:0];
    we             = 1'b0;
    waddr          = count_r[AW-1:0];
    wdata          = '{tag: tag_r, prio: bound_r};
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    sp_nxt         = sp_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_e_nxt     = best_e_r;
    res_status_nxt = res_status_r;
    res_e_nxt      = res_e_r;

    if (cmd.ld_req) begin
      ptr_nxt        = '0;
      found_nxt      = 1'b0;
      res_status_nxt = ST_NOT_FOUND;
      res_e_nxt      = '0;
    end

    if (cmd.ins) begin
      if (full) begin
        res_status_nxt = ST_FULL;
      end else begin
        we             = 1'b1;
        count_nxt      = count_r + CW'(1);
        res_status_nxt = ST_INSERTED;
      end
    end

    if (cmd.scan_en) begin
      if (ptr_r < count_r) begin
        rd_en   = 1'b1;
        rd_addr = ptr_r[AW-1:0];
        ptr_nxt = ptr_r + CW'(1);
      end
      if (rd_vld_r && hit) begin
        found_nxt    = 1'b1;
        best_idx_nxt = rd_idx_r;
        best_e_nxt   = rd_data_r;
      end
    end

    if (cmd.shift_init) begin
      sp_nxt         = CW'(best_idx_r) + CW'(1);
      res_status_nxt = ST_REMOVED;
      res_e_nxt      = best_e_r;
    end

    // each cycle reads slot j+1 and writes what was read last cycle one slot down
    if (cmd.shift_en) begin
      if (sp_r < count_r) begin
        rd_en   = 1'b1;
        rd_addr = sp_r[AW-1:0];
        sp_nxt  = sp_r + CW'(1);
      end
      if (rd_vld_r) begin
        we    = 1'b1;
        waddr = rd_idx_r - AW'(1);
        wdata = rd_data_r;
      end
    end

    if (cmd.rem_commit) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign stat.is_ins     = (req_r == REQ_INSERT);
  assign stat.scan_done  = (ptr_r == count_r) && !rd_vld_r;
  assign stat.found      = found_r;
  assign stat.shift_done = (sp_r >= count_r) && !rd_vld_r;
  assign stat.out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rd_vld_r <= rd_en;
      found_r  <= found_nxt;
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      req_r   <= in_data.req_type;
      tag_r   <= in_data.item_tag;
      bound_r <= (in_data.req_type == REQ_MIN) ? 8'd0 : in_data.item_priority;
    end
    ptr_r        <= ptr_nxt;
    sp_r         <= sp_nxt;
    rd_idx_r     <= rd_addr;
    best_idx_r   <= best_idx_nxt;
    best_e_r     <= best_e_nxt;
    res_status_r <= res_status_nxt;
    res_e_r      <= res_e_nxt;
    if (cmd.out_ld) begin
      out_data_r.status       <= res_status_r;
      out_data_r.out_tag      <= res_e_r.tag;
      out_data_r.out_priority <= res_e_r.prio;
      out_data_r.occupancy    <= occ_ext[4:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_shift_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_init |-> found_r)
    else $error("gap close started without a hit");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || !out_stall))
    else $error("result word overwritten while stalled");

  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    (count_nxt != count_r) |-> ((cmd.ins && !full) || cmd.rem_commit))
    else $error("entry count changed outside insert or remove");
`endif

endmodule

FILE: rtl/priority_queue_select_remove.sv
// Bounded queue of up to QUEUE_DEPTH tagged entries kept in arrival order, with insert,
// remove-exact, remove-at-least and remove-minimum requests; one result word per request
// word. A request word is taken only while the block is idle; a finished result waits in an
// output register, so the next request can be taken before it is drained. An insert writes
// its entry in the EXEC state and loads its result in the DONE state. A removal scans the
// held entries through the single registered read port of the entry memory, then closes the
// gap one entry a cycle; a miss skips the gap closing.
// depends on pqsr_pkg, pqsr_ctrl, pqsr_dp
module priority_queue_select_remove
  import pqsr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  pqsr_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output pqsr_out_t out_data
);

  pqsr_cmd_t  cmd;
  pqsr_stat_t stat;

  pqsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pqsr_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
